// ===== hdl/gram_schmidt_qr_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// gram_schmidt_qr_3x3_assert
// assertion helpers for the rtl files (included by gsqr_back)
// ----------------------------------------------------------------------------
`ifndef GRAM_SCHMIDT_QR_3X3_ASSERT_SVH
`define GRAM_SCHMIDT_QR_3X3_ASSERT_SVH

// same-cycle implication
`define GSQR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSQR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gsqr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsqr_pkg
// shared widths, beat types and rounding helpers for the 3x3 gram-schmidt qr
// ----------------------------------------------------------------------------
package gsqr_pkg;

   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 16;
   localparam int ACC_BITS     = 2 * WORD_BITS + 4;
   localparam int SQ_BITS      = 2 * WORD_BITS;
   localparam int NUM_BITS     = WORD_BITS + FRAC_BITS + 1;
   localparam int SQ_CNT_BITS  = $clog2(WORD_BITS);
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

   localparam logic [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] MAXA = ACC_BITS'(MAXW);
   localparam logic signed [ACC_BITS-1:0] MINA = -MAXA - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   typedef logic [8:0][WORD_BITS-1:0] mat_type;

   typedef struct packed {
      logic [1:0]                 col;
      logic [2:0][WORD_BITS-1:0] q;
      logic [2:0][WORD_BITS-1:0] r;
      logic                       last;
   } res_type;

   // round half up at the binary point, then clamp to one word
   function automatic logic [WORD_BITS-1:0] rnd_sat(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] t;
      t = (v + HALF) >>> FRAC_BITS;
      if (t > MAXA) begin
         return MAXW;
      end else if (t < MINA) begin
         return MINW;
      end else begin
         return t[WORD_BITS-1:0];
      end
   endfunction

endpackage

// ===== hdl/gsqr_front.sv =====
// ----------------------------------------------------------------------------
// gsqr_front
// accepts matrix beats and holds up to two of them for the column engine
// ----------------------------------------------------------------------------
module gsqr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  gsqr_pkg::mat_type in_mat,
   output logic             avail,
   input  logic             take,
   output gsqr_pkg::mat_type out_mat
);
   import gsqr_pkg::*;

   mat_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign full    = (cnt_ff == 2'd2);
   assign avail   = (cnt_ff != 2'd0);
   assign out_mat = slot_ff[rd_ff];
   assign do_wr   = push && !full;
   assign do_rd   = take && avail;

   always_comb begin
      wr_in  = wr_ff ^ do_wr;
      rd_in  = rd_ff ^ do_rd;
      cnt_in = cnt_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ff] <= in_mat;
      end
   end

endmodule

// ===== hdl/gsqr_outq.sv =====
// ----------------------------------------------------------------------------
// gsqr_outq
// two-entry result queue between the column engine and the rsp side
// ----------------------------------------------------------------------------
module gsqr_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  gsqr_pkg::res_type wr_res,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output gsqr_pkg::res_type rd_res
);
   import gsqr_pkg::*;

   res_type    slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   assign full   = (cnt_ff == 2'd2);
   assign empty  = (cnt_ff == 2'd0);
   assign rd_res = slot_ff[rd_ff];
   assign do_wr  = wr && !full;
   assign do_rd  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff ^ do_wr;
      rd_in  = rd_ff ^ do_rd;
      cnt_in = cnt_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ff] <= wr_res;
      end
   end

endmodule

// ===== hdl/gsqr_back.sv =====
// ----------------------------------------------------------------------------
// gsqr_back
// column engine: shared multiplier, bit-serial square root and divider
// ----------------------------------------------------------------------------
module gsqr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              avail,
   input  gsqr_pkg::mat_type in_mat,
   output logic              take,
   input  logic              oq_full,
   output logic              out_push,
   output gsqr_pkg::res_type out_res
);
   import gsqr_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_COL    = 13'b0000000000010,
      ST_DOT    = 13'b0000000000100,
      ST_DOTEND = 13'b0000000001000,
      ST_RESI   = 13'b0000000010000,
      ST_RESM   = 13'b0000000100000,
      ST_RESEND = 13'b0000001000000,
      ST_SQ     = 13'b0000010000000,
      ST_SQRT   = 13'b0000100000000,
      ST_DIVLD  = 13'b0001000000000,
      ST_DIV    = 13'b0010000000000,
      ST_DIVEND = 13'b0100000000000,
      ST_OUT    = 13'b1000000000000
   } st_type;

   st_type                         st_ff, st_in;
   mat_type                        mat_ff, mat_in;
   logic [1:0]                     k_ff, k_in, j_ff, j_in, i_ff, i_in;
   logic                           ph_ff, ph_in;
   logic signed [ACC_BITS-1:0]     acc_ff, acc_in;
   logic signed [SQ_BITS-1:0]      p_ff, p_in;
   logic [2:0][WORD_BITS-1:0]      r_ff, r_in;
   logic [2:0][WORD_BITS-1:0]      v_ff, v_in;
   logic [2:0][2:0][WORD_BITS-1:0] q_ff, q_in;
   logic [SQ_BITS-1:0]             s_ff, s_in, rt_ff, rt_in, bit_ff, bit_in;
   logic [SQ_CNT_BITS-1:0]         sc_ff, sc_in;
   logic [WORD_BITS-1:0]           n_ff, n_in;
   logic [NUM_BITS-1:0]            num_ff, num_in, quo_ff, quo_in;
   logic [WORD_BITS:0]             rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0]        dc_ff, dc_in;

   logic signed [WORD_BITS-1:0]    ma, mb;
   logic [3:0]                     a_idx;
   logic [SQ_BITS-1:0]             sq_t;
   logic [WORD_BITS:0]             rs;
   logic [WORD_BITS-1:0]           vcur, vmag;
   logic [NUM_BITS-1:0]            m;
   logic [WORD_BITS-1:0]           qm;

   assign a_idx    = 4'({2'b0, k_ff} * 4'd3) + 4'(i_ff);
   assign sq_t     = rt_ff + bit_ff;
   assign rs       = {rem_ff[WORD_BITS-1:0], num_ff[NUM_BITS-1]};
   assign vcur     = v_ff[i_ff];
   assign vmag     = vcur[WORD_BITS-1] ? (~vcur + WORD_BITS'(1)) : vcur;
   assign m        = (quo_ff >> 1) + NUM_BITS'(quo_ff[0]);
   assign qm       = (m > NUM_BITS'(MAXW)) ? MAXW : m[WORD_BITS-1:0];
   assign take     = (st_ff == ST_IDLE) && avail;
   assign out_push = (st_ff == ST_OUT) && !oq_full;

   always_comb begin
      out_res.col  = k_ff;
      out_res.q    = q_ff[k_ff];
      out_res.r    = r_ff;
      out_res.last = (k_ff == 2'd2);
   end

   // shared multiplier operands
   always_comb begin
      ma = mat_ff[a_idx];
      mb = q_ff[j_ff][i_ff];
      if (st_ff == ST_RESM) begin
         ma = r_ff[j_ff];
      end else if (st_ff == ST_SQ) begin
         ma = vcur;
         mb = vcur;
      end
   end

   assign p_in = ma * mb;

   always_comb begin
      st_in  = st_ff;
      mat_in = mat_ff;
      k_in   = k_ff;
      j_in   = j_ff;
      i_in   = i_ff;
      ph_in  = ph_ff;
      acc_in = acc_ff;
      r_in   = r_ff;
      v_in   = v_ff;
      q_in   = q_ff;
      s_in   = s_ff;
      rt_in  = rt_ff;
      bit_in = bit_ff;
      sc_in  = sc_ff;
      n_in   = n_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dc_in  = dc_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (avail) begin
               mat_in = in_mat;
               k_in   = 2'd0;
               st_in  = ST_COL;
            end
         end
         ST_COL: begin
            acc_in = '0;
            j_in   = 2'd0;
            i_in   = 2'd0;
            ph_in  = 1'b0;
            r_in   = '0;
            st_in  = (k_ff == 2'd0) ? ST_RESI : ST_DOT;
         end
         ST_DOT: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               acc_in = acc_ff + ACC_BITS'(p_ff);
               if (i_ff == 2'd2) begin
                  i_in  = 2'd0;
                  st_in = ST_DOTEND;
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end
         end
         ST_DOTEND: begin
            r_in[j_ff] = rnd_sat(acc_ff);
            acc_in     = '0;
            if (j_ff == k_ff - 2'd1) begin
               j_in  = 2'd0;
               st_in = ST_RESI;
            end else begin
               j_in  = j_ff + 2'd1;
               st_in = ST_DOT;
            end
         end
         ST_RESI: begin
            acc_in = ACC_BITS'($signed(mat_ff[a_idx])) <<< FRAC_BITS;
            j_in   = 2'd0;
            ph_in  = 1'b0;
            st_in  = (k_ff == 2'd0) ? ST_RESEND : ST_RESM;
         end
         ST_RESM: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               acc_in = acc_ff - ACC_BITS'(p_ff);
               if (j_ff == k_ff - 2'd1) begin
                  st_in = ST_RESEND;
               end else begin
                  j_in = j_ff + 2'd1;
               end
            end
         end
         ST_RESEND: begin
            v_in[i_ff] = rnd_sat(acc_ff);
            if (i_ff == 2'd2) begin
               i_in  = 2'd0;
               s_in  = '0;
               ph_in = 1'b0;
               st_in = ST_SQ;
            end else begin
               i_in  = i_ff + 2'd1;
               st_in = ST_RESI;
            end
         end
         ST_SQ: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               s_in = s_ff + p_ff;
               if (i_ff == 2'd2) begin
                  i_in   = 2'd0;
                  rt_in  = '0;
                  bit_in = SQ_BITS'(1) << (SQ_BITS - 2);
                  sc_in  = '0;
                  st_in  = ST_SQRT;
               end else begin
                  i_in = i_ff + 2'd1;
               end
            end
         end
         ST_SQRT: begin
            // one result bit per beat of the digit-by-digit root
            if (s_ff >= sq_t) begin
               s_in  = s_ff - sq_t;
               rt_in = (rt_ff >> 1) + bit_ff;
            end else begin
               rt_in = rt_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            sc_in  = sc_ff + SQ_CNT_BITS'(1);
            if (sc_ff == SQ_CNT_BITS'(WORD_BITS - 1)) begin
               n_in      = rt_in[WORD_BITS-1:0];
               r_in[k_ff] = (n_in > MAXW) ? MAXW : n_in;
               i_in      = 2'd0;
               if (n_in == '0) begin
                  q_in[k_ff] = '0;
                  st_in      = ST_OUT;
               end else begin
                  st_in = ST_DIVLD;
               end
            end
         end
         ST_DIVLD: begin
            num_in = {vmag, (FRAC_BITS + 1)'(0)};
            rem_in = '0;
            quo_in = '0;
            dc_in  = '0;
            st_in  = ST_DIV;
         end
         ST_DIV: begin
            if (rs >= {1'b0, n_ff}) begin
               rem_in = rs - {1'b0, n_ff};
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = rs;
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            dc_in  = dc_ff + DIV_CNT_BITS'(1);
            if (dc_ff == DIV_CNT_BITS'(NUM_BITS - 1)) begin
               st_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            q_in[k_ff][i_ff] = vcur[WORD_BITS-1] ? (~qm + WORD_BITS'(1)) : qm;
            if (i_ff == 2'd2) begin
               st_in = ST_OUT;
            end else begin
               i_in  = i_ff + 2'd1;
               st_in = ST_DIVLD;
            end
         end
         ST_OUT: begin
            if (!oq_full) begin
               if (k_ff == 2'd2) begin
                  st_in = ST_IDLE;
               end else begin
                  k_in  = k_ff + 2'd1;
                  st_in = ST_COL;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         k_ff  <= 2'd0;
         j_ff  <= 2'd0;
         i_ff  <= 2'd0;
         ph_ff <= 1'b0;
         sc_ff <= '0;
         dc_ff <= '0;
      end else begin
         st_ff <= st_in;
         k_ff  <= k_in;
         j_ff  <= j_in;
         i_ff  <= i_in;
         ph_ff <= ph_in;
         sc_ff <= sc_in;
         dc_ff <= dc_in;
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
      acc_ff <= acc_in;
      p_ff   <= p_in;
      r_ff   <= r_in;
      v_ff   <= v_in;
      q_ff   <= q_in;
      s_ff   <= s_in;
      rt_ff  <= rt_in;
      bit_ff <= bit_in;
      n_ff   <= n_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

`include "gram_schmidt_qr_3x3_assert.svh"

   `GSQR_ASSERT_NOW(a_div_norm, st_ff == ST_DIV, n_ff != '0, "divide with zero norm")
   `GSQR_ASSERT_NOW(a_col_range, st_ff != ST_IDLE, k_ff != 2'd3, "column index out of range")
   `GSQR_ASSERT_NEXT(a_last_idle, out_push && (k_ff == 2'd2), st_ff == ST_IDLE, "idle missed")
   `GSQR_ASSERT_NOW(a_take_idle, take, !out_push, "take during result beat")

endmodule

// ===== hdl/gram_schmidt_qr_3x3.sv =====
// ----------------------------------------------------------------------------
// gram_schmidt_qr_3x3
// classical gram-schmidt qr of one 3x3 q15.16 matrix per req beat
// ----------------------------------------------------------------------------
// req side: write a matrix while full is low by raising push; the nine
//   req_a_* ports carry it, column by column
// rsp side: while empty is low the oldest column result sits on rsp_*;
//   pop takes it. three results per matrix, columns 0, 1, 2, the third
//   with rsp_last_col high
// a two-deep matrix queue sits in front of the engine and a two-deep
//   result queue behind it, so push keeps going while results wait
// the engine works on one matrix at a time and takes the next only after
//   its third column result is queued; its pace is set by the shared restoring
//   divider, 49 steps per q entry, and the 32-step square root
// a stalled rsp side holds the engine at its result beat; nothing is lost
// reset clears both queues and returns the engine to idle
// ----------------------------------------------------------------------------
module gram_schmidt_qr_3x3 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r1_c1,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r2_c1,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r3_c1,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r1_c2,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r2_c2,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r3_c2,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r1_c3,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r2_c3,
   input  logic signed [gsqr_pkg::WORD_BITS-1:0] req_a_r3_c3,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [1:0]                           rsp_col_index,
   output logic signed [gsqr_pkg::WORD_BITS-1:0] rsp_q_row1,
   output logic signed [gsqr_pkg::WORD_BITS-1:0] rsp_q_row2,
   output logic signed [gsqr_pkg::WORD_BITS-1:0] rsp_q_row3,
   output logic signed [gsqr_pkg::WORD_BITS-1:0] rsp_r_row1,
   output logic signed [gsqr_pkg::WORD_BITS-1:0] rsp_r_row2,
   output logic signed [gsqr_pkg::WORD_BITS-1:0] rsp_r_row3,
   output logic                                 rsp_last_col
);
   import gsqr_pkg::*;

   mat_type in_mat, eng_mat;
   res_type eng_res, rd_res;
   logic    avail, take, oq_full, eng_push;

   assign in_mat = {req_a_r3_c3, req_a_r2_c3, req_a_r1_c3,
                    req_a_r3_c2, req_a_r2_c2, req_a_r1_c2,
                    req_a_r3_c1, req_a_r2_c1, req_a_r1_c1};

   gsqr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .in_mat  (in_mat),
      .avail   (avail),
      .take    (take),
      .out_mat (eng_mat)
   );

   gsqr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .avail    (avail),
      .in_mat   (eng_mat),
      .take     (take),
      .oq_full  (oq_full),
      .out_push (eng_push),
      .out_res  (eng_res)
   );

   gsqr_outq u_outq (
      .clock  (clock),
      .reset  (reset),
      .wr     (eng_push),
      .wr_res (eng_res),
      .full   (oq_full),
      .empty  (empty),
      .pop    (pop),
      .rd_res (rd_res)
   );

   assign rsp_col_index = rd_res.col;
   assign rsp_q_row1    = rd_res.q[0];
   assign rsp_q_row2    = rd_res.q[1];
   assign rsp_q_row3    = rd_res.q[2];
   assign rsp_r_row1    = rd_res.r[0];
   assign rsp_r_row2    = rd_res.r[1];
   assign rsp_r_row3    = rd_res.r[2];
   assign rsp_last_col  = rd_res.last;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the 3x3 gram-schmidt qr block: matrices go in on
// the req queue, each one gives three column beats that are checked against
// an exact wide-integer model of the decomposition
// ----------------------------------------------------------------------------
module tb;
   import gsqr_pkg::*;

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int N_RANDOM = 455;
   localparam int N_CALM   = 60;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [1:0]         col;
      logic [2:0][W-1:0]  q;
      logic [2:0][W-1:0]  r;
      logic               last;
   } col_beat_type;

   localparam wide_type MAXV = (wide_type'(1) <<< (W - 1)) - 1;
   localparam wide_type MINV = -MAXV - 1;

   function automatic wide_type clamp_word(input wide_type v);
      if (v > MAXV) return MAXV;
      if (v < MINV) return MINV;
      return v;
   endfunction

   // round half up at the binary point
   function automatic wide_type round_frac(input wide_type v);
      return (v + (wide_type'(1) <<< (F - 1))) >>> F;
   endfunction

   function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
      logic [127:0] res, bitv, t;
      res  = '0;
      bitv = 128'd1 << 126;
      for (int i = 0; i < 64; i++) begin
         t = res + bitv;
         if (x >= t) begin
            x   = x - t;
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   class qr_scoreboard;
      col_beat_type pending_cols[$];
      int           errors;
      int           matrices;
      int           columns;

      function new();
         errors   = 0;
         matrices = 0;
         columns  = 0;
      endfunction

      // work out all three column beats of one accepted matrix
      function void note_matrix(input mat_type m);
         wide_type     a[3], qv[3][3], rv[3], v[3], acc, s;
         logic [127:0] n, num, quo, mg;
         col_beat_type b;
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) a[i] = wide_type'($signed(m[k*3+i]));
            for (int j = 0; j < 3; j++) rv[j] = 0;
            for (int j = 0; j < k; j++) begin
               acc = 0;
               for (int i = 0; i < 3; i++) acc = acc + a[i] * qv[j][i];
               rv[j] = clamp_word(round_frac(acc));
            end
            s = 0;
            for (int i = 0; i < 3; i++) begin
               acc = a[i] <<< F;
               for (int j = 0; j < k; j++) acc = acc - rv[j] * qv[j][i];
               v[i] = clamp_word(round_frac(acc));
               s = s + v[i] * v[i];
            end
            n = floor_sqrt(s);
            rv[k] = (n > MAXV) ? MAXV : wide_type'(n);
            for (int i = 0; i < 3; i++) begin
               mg = '0;
               if (n != 0) begin
                  num = (v[i] < 0 ? -v[i] : v[i]) << (F + 1);
                  quo = num / n;
                  mg  = (quo >> 1) + (quo & 1);
                  if (mg > MAXV) mg = MAXV;
               end
               qv[k][i] = v[i] < 0 ? -wide_type'(mg) : wide_type'(mg);
            end
            b.col  = 2'(k);
            b.last = (k == 2);
            for (int i = 0; i < 3; i++) begin
               b.q[i] = qv[k][i][W-1:0];
               b.r[i] = rv[i][W-1:0];
            end
            pending_cols.push_back(b);
         end
         matrices++;
      endfunction

      function void check_beat(input col_beat_type got);
         col_beat_type e;
         if (pending_cols.size() == 0) begin
            $display("%0t: column beat with nothing expected, col %0d", $time, got.col);
            errors++;
            return;
         end
         e = pending_cols.pop_front();
         columns++;
         if (got.col !== e.col) begin
            $display("%0t: col_index expected %0d actual %0d", $time, e.col, got.col);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last_col expected %0b actual %0b", $time, e.last, got.last);
            errors++;
         end
         for (int i = 0; i < 3; i++) begin
            if (got.q[i] !== e.q[i]) begin
               $display("%0t: col %0d q_row%0d expected %0d actual %0d", $time, e.col,
                        i + 1, $signed(e.q[i]), $signed(got.q[i]));
               errors++;
            end
            if (got.r[i] !== e.r[i]) begin
               $display("%0t: col %0d r_row%0d expected %0d actual %0d", $time, e.col,
                        i + 1, $signed(e.r[i]), $signed(got.r[i]));
               errors++;
            end
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   mat_type           mat_d;
   logic              empty;
   logic              pop;
   logic [1:0]        rsp_col_index;
   logic signed [W-1:0] rsp_q_row1, rsp_q_row2, rsp_q_row3;
   logic signed [W-1:0] rsp_r_row1, rsp_r_row2, rsp_r_row3;
   logic              rsp_last_col;
   logic              calm;
   int                pop_gap;
   qr_scoreboard      sb;

   gram_schmidt_qr_3x3 u_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_a_r1_c1   (mat_d[0]),
      .req_a_r2_c1   (mat_d[1]),
      .req_a_r3_c1   (mat_d[2]),
      .req_a_r1_c2   (mat_d[3]),
      .req_a_r2_c2   (mat_d[4]),
      .req_a_r3_c2   (mat_d[5]),
      .req_a_r1_c3   (mat_d[6]),
      .req_a_r2_c3   (mat_d[7]),
      .req_a_r3_c3   (mat_d[8]),
      .empty         (empty),
      .pop           (pop),
      .rsp_col_index (rsp_col_index),
      .rsp_q_row1    (rsp_q_row1),
      .rsp_q_row2    (rsp_q_row2),
      .rsp_q_row3    (rsp_q_row3),
      .rsp_r_row1    (rsp_r_row1),
      .rsp_r_row2    (rsp_r_row2),
      .rsp_r_row3    (rsp_r_row3),
      .rsp_last_col  (rsp_last_col)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // hold one matrix on req until the beat is taken, then maybe idle a burst
   task automatic send_matrix(input mat_type m);
      mat_d <= m;
      push  <= 1'b1;
      do @(posedge clock); while (full);
      sb.note_matrix(m);
      if (!calm && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic [W-1:0] pick_entry(input int mode);
      logic [W-1:0] x;
      case (mode)
         0: x = $urandom;
         1: x = W'($signed($urandom) >>> $urandom_range(8, 30));
         2: begin
            case ($urandom_range(0, 4))
               0: x = MAXW;
               1: x = MINW;
               2: x = '0;
               3: x = W'(1 << F);
               default: x = '1;
            endcase
         end
         default: x = W'($signed($urandom) >>> $urandom_range(0, 30));
      endcase
      return x;
   endfunction

   function automatic mat_type random_matrix();
      mat_type m;
      int      mode, kind;
      mode = $urandom_range(0, 3);
      for (int e = 0; e < 9; e++) m[e] = pick_entry(mode);
      kind = $urandom_range(0, 9);
      // dependent or empty columns drive the zero-norm path
      if (kind == 0) begin
         for (int i = 0; i < 3; i++) m[3+i] = m[i];
      end else if (kind == 1) begin
         for (int i = 0; i < 3; i++) m[6+i] = m[3+i];
      end else if (kind == 2) begin
         for (int i = 0; i < 3; i++) m[$urandom_range(0, 2)*3+i] = '0;
      end
      return m;
   endfunction

   task automatic run_directed();
      mat_type m;
      m = '0;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = (e % 4 == 0) ? W'(1 << F) : '0;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = MAXW;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = MINW;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = (e % 2) ? MINW : MAXW;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = (e % 4 == 0) ? MINW : MAXW;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = '1;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = W'(e + 1);
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = W'((e + 1) << F);
      send_matrix(m);
      // zero first column, then a repeated column
      m = '0;
      m[4] = W'(3 << F);
      m[8] = W'(-(5 << F));
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = W'((e % 3 + 2) << F);
      send_matrix(m);
      for (int e = 0; e < 6; e++) m[e] = (e < 3) ? W'(7 << F) : W'(-(7 << F));
      m[6] = '0; m[7] = '0; m[8] = '0;
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = (e % 3 == 1) ? MINW : W'(1);
      send_matrix(m);
      for (int e = 0; e < 9; e++) m[e] = W'($signed(-(e + 1)) <<< (F - 4));
      send_matrix(m);
   endtask

   initial begin
      sb      = new();
      calm    = 1'b0;
      reset   = 1'b1;
      push    = 1'b0;
      pop     = 1'b0;
      mat_d   = '0;
      pop_gap = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - N_CALM) calm = 1'b1;
         send_matrix(random_matrix());
      end
      push <= 1'b0;
      while (sb.pending_cols.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("covered %0d matrices, %0d column beats checked", sb.matrices, sb.columns);
      $display("extremes, zero and dependent columns, random magnitudes, idle bursts");
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // rsp side: check each popped beat, stall in random bursts
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            sb.check_beat('{col: rsp_col_index,
                            q: {rsp_q_row3, rsp_q_row2, rsp_q_row1},
                            r: {rsp_r_row3, rsp_r_row2, rsp_r_row1},
                            last: rsp_last_col});
         end
         if (pop_gap > 0) begin
            pop_gap--;
            pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            pop_gap = $urandom_range(1, 8) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
